[rtl/core/photon_cut_id_classifier_unit_macros.svh]
// ---------------------------------------------------------------------------
// Photon cut ID classifier: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PHOTON_CUT_ID_CLASSIFIER_UNIT_MACROS_SVH
`define PHOTON_CUT_ID_CLASSIFIER_UNIT_MACROS_SVH

// same-cycle implication
`define PCID_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCID_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/pcid_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Photon cut ID package
// Types, cut tables and effective areas shared by the pipeline stages.
// ---------------------------------------------------------------------------
package pcid_pkg;

  typedef enum logic {
    REGION_BARREL,
    REGION_ENDCAP
  } region_e;

  typedef enum logic [1:0] {
    EA_INNER,
    EA_OUTER,
    EA_NONE
  } ea_bin_e;

  typedef enum logic [1:0] {
    ISO_CHG,
    ISO_NEU,
    ISO_PHO
  } iso_e;

  typedef enum logic [1:0] {
    WP_LOOSE,
    WP_MEDIUM,
    WP_TIGHT
  } wp_e;

  localparam int NumWp = 3;

  // |eta| edges in eta LSBs, scaled by 1000 and 10000
  localparam logic [13:0] EtaInnerEdge  = 14'd1024;
  localparam logic [23:0] EtaEaEdgeK    = 24'd1514496;
  localparam logic [26:0] EtaBarrelEdge = 27'd14788608;

  typedef struct packed {
    logic [7:0]  tag;
    logic [17:0] pt;
    region_e     region;
    ea_bin_e     ea_bin;
    logic [15:0] hoe;
    logic [15:0] sie;
    logic [17:0] chg;
    logic [17:0] neu;
    logic [17:0] pho;
    logic [13:0] rho;
    logic        seed;
  } dec_t;

  typedef struct packed {
    logic [7:0]       tag;
    region_e          region;
    logic             seed;
    logic [NumWp-1:0] hs_pass;
    logic [31:0]      iso_c;
    logic [31:0]      iso_n;
    logic [31:0]      iso_p;
    logic [24:0]      rea_c;
    logic [24:0]      rea_n;
    logic [24:0]      rea_p;
    logic [35:0]      pt_sq;
    logic [25:0]      nb_pt;
    logic [23:0]      pb_pt;
  } prod_t;

  typedef struct packed {
    logic [7:0]       tag;
    region_e          region;
    logic             seed;
    logic [NumWp-1:0] hs_pass;
    logic [31:0]      x_c;
    logic [31:0]      x_n;
    logic [31:0]      x_p;
    logic [41:0]      n_var;
    logic [23:0]      p_var;
  } corr_t;

  function automatic logic [9:0] hoe_cut(region_e r, wp_e w);
    logic [9:0] v;
    case (w)
      WP_LOOSE:  v = (r == REGION_BARREL) ? 10'd597 : 10'd481;
      WP_MEDIUM: v = (r == REGION_BARREL) ? 10'd396 : 10'd209;
      WP_TIGHT:  v = (r == REGION_BARREL) ? 10'd269 : 10'd213;
      default:   v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [11:0] sie_cut(region_e r, wp_e w);
    logic [11:0] v;
    case (w)
      WP_LOOSE:  v = (r == REGION_BARREL) ? 12'd1031 : 12'd3013;
      WP_MEDIUM: v = (r == REGION_BARREL) ? 12'd1022 : 12'd3001;
      WP_TIGHT:  v = (r == REGION_BARREL) ? 12'd994  : 12'd3000;
      default:   v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [10:0] chg_cut(region_e r, wp_e w);
    logic [10:0] v;
    case (w)
      WP_LOOSE:  v = (r == REGION_BARREL) ? 11'd1295 : 11'd1011;
      WP_MEDIUM: v = (r == REGION_BARREL) ? 11'd441  : 11'd442;
      WP_TIGHT:  v = (r == REGION_BARREL) ? 11'd202  : 11'd34;
      default:   v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [13:0] neu_a(region_e r, wp_e w);
    logic [13:0] v;
    case (w)
      WP_LOOSE:  v = (r == REGION_BARREL) ? 14'd10910 : 14'd5931;
      WP_MEDIUM: v = (r == REGION_BARREL) ? 14'd2725  : 14'd1715;
      WP_TIGHT:  v = (r == REGION_BARREL) ? 14'd264   : 14'd586;
      default:   v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [12:0] pho_a(region_e r, wp_e w);
    logic [12:0] v;
    case (w)
      WP_LOOSE:  v = (r == REGION_BARREL) ? 13'd3630 : 13'd6641;
      WP_MEDIUM: v = (r == REGION_BARREL) ? 13'd2571 : 13'd3863;
      WP_TIGHT:  v = (r == REGION_BARREL) ? 13'd2362 : 13'd2617;
      default:   v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] neu_b(region_e r);
    return (r == REGION_BARREL) ? 8'd148 : 8'd163;
  endfunction

  function automatic logic [4:0] neu_c(region_e r);
    return (r == REGION_BARREL) ? 5'd17 : 5'd14;
  endfunction

  function automatic logic [5:0] pho_b(region_e r);
    return (r == REGION_BARREL) ? 6'd47 : 6'd34;
  endfunction

  function automatic logic [10:0] ea_area(ea_bin_e b, iso_e k);
    logic [10:0] v;
    v = '0;
    case (b)
      EA_INNER: begin
        case (k)
          ISO_CHG: v = 11'd360;
          ISO_NEU: v = 11'd597;
          ISO_PHO: v = 11'd1210;
          default: v = '0;
        endcase
      end
      EA_OUTER: begin
        case (k)
          ISO_CHG: v = 11'd377;
          ISO_NEU: v = 11'd807;
          ISO_PHO: v = 11'd1107;
          default: v = '0;
        endcase
      end
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/pcid_decode.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Photon cut ID: decode stage
// Takes |eta|, picks the cut region and effective-area bin, registers inputs.
// ---------------------------------------------------------------------------
module pcid_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [7:0]         photon_tag_i,
  input  logic [17:0]        pt_gev_i,
  input  logic signed [13:0] eta_val_i,
  input  logic [15:0]        h_over_e_i,
  input  logic [15:0]        sigma_ieta_i,
  input  logic [17:0]        charged_iso_i,
  input  logic [17:0]        neutral_iso_i,
  input  logic [17:0]        gamma_iso_i,
  input  logic [13:0]        event_rho_i,
  input  logic               has_pixel_seed_i,
  output logic               valid_o,
  output pcid_pkg::dec_t     data_o
);
  import pcid_pkg::*;

  logic [13:0] aeta;
  logic [23:0] aeta_k;
  logic [26:0] aeta_m;
  dec_t        data_d;
  dec_t        data_q;
  logic        valid_q;

  always_comb begin
    aeta   = eta_val_i[13] ? (~$unsigned(eta_val_i) + 14'd1) : $unsigned(eta_val_i);
    aeta_k = 24'(aeta) * 24'd1000;
    aeta_m = 27'(aeta) * 27'd10000;

    data_d.tag    = photon_tag_i;
    data_d.pt     = pt_gev_i;
    data_d.region = (aeta_m < EtaBarrelEdge) ? REGION_BARREL : REGION_ENDCAP;
    if (aeta < EtaInnerEdge) begin
      data_d.ea_bin = EA_INNER;
    end else if (aeta_k < EtaEaEdgeK) begin
      data_d.ea_bin = EA_OUTER;
    end else begin
      data_d.ea_bin = EA_NONE;
    end
    data_d.hoe  = h_over_e_i;
    data_d.sie  = sigma_ieta_i;
    data_d.chg  = charged_iso_i;
    data_d.neu  = neutral_iso_i;
    data_d.pho  = gamma_iso_i;
    data_d.rho  = event_rho_i;
    data_d.seed = has_pixel_seed_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/core/pcid_product.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Photon cut ID: product stage
// Scales isolations, forms rho x area, pt products, and H/E, sigma passes.
// ---------------------------------------------------------------------------
module pcid_product (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  pcid_pkg::dec_t  data_i,
  output logic            valid_o,
  output pcid_pkg::prod_t data_o
);
  import pcid_pkg::*;

  prod_t data_d;
  prod_t data_q;
  logic  valid_q;

  always_comb begin
    data_d.tag    = data_i.tag;
    data_d.region = data_i.region;
    data_d.seed   = data_i.seed;
    for (int k = 0; k < NumWp; k++) begin
      data_d.hs_pass[k] =
        (30'(data_i.hoe) * 30'd10000 <
         30'(hoe_cut(data_i.region, wp_e'(2'(k)))) * 30'd65536) &&
        (33'(data_i.sie) * 33'd100000 <
         33'(sie_cut(data_i.region, wp_e'(2'(k)))) * 33'd1048576);
    end
    data_d.iso_c = 32'(data_i.chg) * 32'd10000;
    data_d.iso_n = 32'(data_i.neu) * 32'd10000;
    data_d.iso_p = 32'(data_i.pho) * 32'd10000;
    data_d.rea_c = 25'(data_i.rho) * 25'(ea_area(data_i.ea_bin, ISO_CHG));
    data_d.rea_n = 25'(data_i.rho) * 25'(ea_area(data_i.ea_bin, ISO_NEU));
    data_d.rea_p = 25'(data_i.rho) * 25'(ea_area(data_i.ea_bin, ISO_PHO));
    data_d.pt_sq = 36'(data_i.pt) * 36'(data_i.pt);
    data_d.nb_pt = 26'(data_i.pt) * 26'(neu_b(data_i.region));
    data_d.pb_pt = 24'(data_i.pt) * 24'(pho_b(data_i.region));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/core/pcid_correct.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Photon cut ID: correction stage
// Subtracts pileup from each isolation with clamp, builds pt-dependent terms.
// ---------------------------------------------------------------------------
module pcid_correct (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  pcid_pkg::prod_t data_i,
  output logic            valid_o,
  output pcid_pkg::corr_t data_o
);
  import pcid_pkg::*;

  logic [32:0] diff_c;
  logic [32:0] diff_n;
  logic [32:0] diff_p;
  corr_t       data_d;
  corr_t       data_q;
  logic        valid_q;

  always_comb begin
    diff_c = {1'b0, data_i.iso_c} - 33'(data_i.rea_c);
    diff_n = {1'b0, data_i.iso_n} - 33'(data_i.rea_n);
    diff_p = {1'b0, data_i.iso_p} - 33'(data_i.rea_p);

    data_d.tag     = data_i.tag;
    data_d.region  = data_i.region;
    data_d.seed    = data_i.seed;
    data_d.hs_pass = data_i.hs_pass;
    data_d.x_c     = diff_c[32] ? '0 : diff_c[31:0];
    data_d.x_n     = diff_n[32] ? '0 : diff_n[31:0];
    data_d.x_p     = diff_p[32] ? '0 : diff_p[31:0];
    data_d.n_var   = 42'(data_i.nb_pt) * 42'd6400 +
                     42'(data_i.pt_sq) * 42'(neu_c(data_i.region));
    data_d.p_var   = data_i.pb_pt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/core/photon_cut_id_classifier_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Photon cut ID classifier
// Four-stage pipeline testing one photon per clock (while the output is not
// stalled) against loose, medium, tight and medium-with-pixel-seed working points.
//
// channel  direction  handshake                payload
// in       input      in_valid_i / in_ready_o  photon_tag_i .. has_pixel_seed_i
// out      output     out_valid_o / out_ready_i photon_tag_out_o, pass_*_o
//
// One transaction per cycle while the output is not stalled.
// Stages: eta decode, products, pileup correction, threshold compare.
// All stages advance together; a stalled output freezes the whole pipeline.
// in_ready_o is high when the output register is empty or being taken.
// Reset clears the stage valid bits only.
// ---------------------------------------------------------------------------
`include "photon_cut_id_classifier_unit_macros.svh"

module photon_cut_id_classifier_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         photon_tag_i,
  input  logic [17:0]        pt_gev_i,
  input  logic signed [13:0] eta_val_i,
  input  logic [15:0]        h_over_e_i,
  input  logic [15:0]        sigma_ieta_i,
  input  logic [17:0]        charged_iso_i,
  input  logic [17:0]        neutral_iso_i,
  input  logic [17:0]        gamma_iso_i,
  input  logic [13:0]        event_rho_i,
  input  logic               has_pixel_seed_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         photon_tag_out_o,
  output logic               pass_loose_o,
  output logic               pass_medium_o,
  output logic               pass_tight_o,
  output logic               pass_medium_seeded_o
);
  import pcid_pkg::*;

  logic             en;
  logic             s1_valid;
  logic             s2_valid;
  logic             s3_valid;
  dec_t             s1_data;
  prod_t            s2_data;
  corr_t            s3_data;
  logic [NumWp-1:0] pass;
  logic             out_valid_q;
  logic [7:0]       tag_q;
  logic [3:0]       flags_d;
  logic [3:0]       flags_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  pcid_decode u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .valid_i         (in_valid_i),
    .photon_tag_i    (photon_tag_i),
    .pt_gev_i        (pt_gev_i),
    .eta_val_i       (eta_val_i),
    .h_over_e_i      (h_over_e_i),
    .sigma_ieta_i    (sigma_ieta_i),
    .charged_iso_i   (charged_iso_i),
    .neutral_iso_i   (neutral_iso_i),
    .gamma_iso_i     (gamma_iso_i),
    .event_rho_i     (event_rho_i),
    .has_pixel_seed_i(has_pixel_seed_i),
    .valid_o         (s1_valid),
    .data_o          (s1_data)
  );

  pcid_product u_product (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s1_valid),
    .data_i (s1_data),
    .valid_o(s2_valid),
    .data_o (s2_data)
  );

  pcid_correct u_correct (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s2_valid),
    .data_i (s2_data),
    .valid_o(s3_valid),
    .data_o (s3_data)
  );

  always_comb begin
    for (int k = 0; k < NumWp; k++) begin
      pass[k] = s3_data.hs_pass[k] &&
        (s3_data.x_c < 32'(chg_cut(s3_data.region, wp_e'(2'(k)))) * 32'd640) &&
        (s3_data.x_p < 32'(pho_a(s3_data.region, wp_e'(2'(k)))) * 32'd640 +
                       32'(s3_data.p_var)) &&
        (45'(s3_data.x_n) * 45'd6400 <
         45'(neu_a(s3_data.region, wp_e'(2'(k)))) * 45'd4096000 + 45'(s3_data.n_var));
    end
    flags_d[0] = pass[WP_LOOSE]  && !s3_data.seed;
    flags_d[1] = pass[WP_MEDIUM] && !s3_data.seed;
    flags_d[2] = pass[WP_TIGHT]  && !s3_data.seed;
    flags_d[3] = pass[WP_MEDIUM] &&  s3_data.seed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s3_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag_q   <= s3_data.tag;
      flags_q <= flags_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign photon_tag_out_o     = tag_q;
  assign pass_loose_o         = flags_q[0];
  assign pass_medium_o        = flags_q[1];
  assign pass_tight_o         = flags_q[2];
  assign pass_medium_seeded_o = flags_q[3];

  `PCID_ASSERT_IMP(a_seed_excl, out_valid_o && pass_medium_seeded_o, !pass_loose_o && !pass_medium_o && !pass_tight_o, "seeded pass overlaps unseeded pass")
  `PCID_ASSERT_NXT(a_latency, (in_valid_i && in_ready_o) ##1 en ##1 en ##1 en, out_valid_o, "accepted transaction did not reach output")
  `PCID_ASSERT_NXT(a_stall_hold, s3_valid && out_valid_o && !out_ready_i, s3_valid, "stage three lost a transaction while stalled")

endmodule
